// ===== hdl/spsu_pkg.sv =====
// ----------------------------------------------------------------------------
// spsu_pkg
// Shared types, constants and the seed prime table of the prime sieve unit.
// ----------------------------------------------------------------------------
package spsu_pkg;

    localparam int TABLE_DEPTH_DEF  = 4096;
    localparam int SEGMENT_BITS_DEF = 4096;
    localparam int PRIME_BITS_DEF   = 32;

    localparam int IDX_W = 12;
    localparam int CNT_W = 13;
    localparam int VAL_W = 32;
    localparam int LIM_W = 13;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;
    localparam int SEED_COUNT     = 9;
    localparam int FIRST_UNSIEVED = 25;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LAST_RD,
        ST_SQ,
        ST_SIZE,
        ST_FILL,
        ST_KRD,
        ST_KDIV,
        ST_KWAIT,
        ST_KFIRST,
        ST_STRIKE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_COMMIT,
        ST_ANS_RD,
        ST_ANS,
        ST_ERR
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_LAST,
        OP_SQUARE,
        OP_SIZE,
        OP_FILL,
        OP_RD_PRIME,
        OP_DIV_START,
        OP_FIRST,
        OP_STRIKE,
        OP_K_NEXT,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_COMMIT,
        OP_RD_ANS,
        OP_OUT_OK,
        OP_OUT_ERR
    } t_op;

    typedef struct packed {
        logic want_oor;
        logic want_known;
        logic full;
        logic exhausted;
        logic fill_last;
        logic k_done;
        logic div_done;
        logic strike_go;
        logic scan_end;
        logic out_free;
    } t_status;

    function automatic logic [VAL_W-1:0] seed_prime(input logic [3:0] idx);
        logic [VAL_W-1:0] v;
        case (idx)
            4'd0:    v = 32'd2;
            4'd1:    v = 32'd3;
            4'd2:    v = 32'd5;
            4'd3:    v = 32'd7;
            4'd4:    v = 32'd11;
            4'd5:    v = 32'd13;
            4'd6:    v = 32'd17;
            4'd7:    v = 32'd19;
            4'd8:    v = 32'd23;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/spsu_if.sv =====
// ----------------------------------------------------------------------------
// spsu_req_if / spsu_res_if
// Valid/ready channels for requests and results of the prime sieve unit.
// ----------------------------------------------------------------------------
interface spsu_req_if;
    logic                        valid;
    logic                        ready;
    logic [spsu_pkg::IDX_W-1:0]  wanted_index;

    modport source (output valid, output wanted_index, input ready);
    modport sink   (input valid, input wanted_index, output ready);
endinterface

interface spsu_res_if;
    logic                        valid;
    logic                        ready;
    logic [spsu_pkg::VAL_W-1:0]  prime_value;
    logic [spsu_pkg::CNT_W-1:0]  known_count;
    logic                        status;

    modport source (output valid, output prime_value, output known_count,
                    output status, input ready);
    modport sink   (input valid, input prime_value, input known_count,
                    input status, output ready);
endinterface

// ===== hdl/segmented_prime_sieve_unit.sv =====
// ----------------------------------------------------------------------------
// segmented_prime_sieve_unit
// Prime lookup by index with a table that grows by segmented sieving on demand.
// ----------------------------------------------------------------------------
// Lookup: a request whose prime is already in the table passes the check, table
// read and answer states, and the answer state waits until the result register is
// free. A miss sieves segments first; each segment is sized, filled, struck by
// every known odd prime through the one-bit-per-cycle divider, then scanned
// for new primes in the sieve flag memory.
// Throughput: one request in flight; the next is taken while a result waits.
// Reset (synchronous, active low): nine seed primes, count 9, limit 4096.

module segmented_prime_sieve_unit #(
    parameter int TABLE_DEPTH  = spsu_pkg::TABLE_DEPTH_DEF,
    parameter int SEGMENT_BITS = spsu_pkg::SEGMENT_BITS_DEF,
    parameter int PRIME_BITS   = spsu_pkg::PRIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [spsu_pkg::LIM_W-1:0]  i_cfg_wdata,
    spsu_req_if.sink                    i_req,
    spsu_res_if.source                  o_res
);
    // The controller issues one datapath operation per cycle and branches on
    // the status the datapath returns. The prime table and the sieve flags
    // live in RAMs inside the datapath; the first nine primes come from a
    // constant table, so the table needs no clearing pass after reset.
    spsu_pkg::t_op     op;
    spsu_pkg::t_status status;

    spsu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready),
        .i_status  (status),
        .o_op      (op)
    );

    // The result register sits in the datapath; a finished result is held
    // there until its transfer completes, while a new request can be taken.
    spsu_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SEGMENT_BITS(SEGMENT_BITS),
        .PRIME_BITS  (PRIME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .o_flags       (status),
        .i_wanted_index(i_req.wanted_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_prime_value (o_res.prime_value),
        .o_known_count (o_res.known_count),
        .o_status      (o_res.status)
    );
endmodule

// ===== hdl/spsu_ram.sv =====
// ----------------------------------------------------------------------------
// spsu_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module spsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/spsu_div.sv =====
// ----------------------------------------------------------------------------
// spsu_div
// Restoring divider, one quotient bit per cycle; gives remainder and quotient LSB.
// ----------------------------------------------------------------------------
module spsu_div #(
    parameter int PRIME_BITS = spsu_pkg::PRIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [PRIME_BITS-1:0] i_dividend,
    input  logic [PRIME_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [PRIME_BITS-1:0] o_rem,
    output logic                  o_q_lsb
);
    localparam int CW = $clog2(PRIME_BITS + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [PRIME_BITS-1:0] r_rem, n_rem;
    logic [PRIME_BITS-1:0] r_num, n_num;
    logic [PRIME_BITS-1:0] r_div, n_div;
    logic [PRIME_BITS:0]   rem_sh;
    logic                  ge;

    assign rem_sh = {r_rem, r_num[PRIME_BITS-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
            n_rem  = '0;
            n_num  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? PRIME_BITS'(rem_sh - {1'b0, r_div}) : PRIME_BITS'(rem_sh);
            n_num = {r_num[PRIME_BITS-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(PRIME_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_num <= n_num;
        r_div <= n_div;
    end

    assign o_done  = r_done;
    assign o_rem   = r_rem;
    assign o_q_lsb = r_num[0];
endmodule

// ===== hdl/spsu_datapath.sv =====
// ----------------------------------------------------------------------------
// spsu_datapath
// Prime table, sieve flags, segment arithmetic and the result register.
// ----------------------------------------------------------------------------
module spsu_datapath #(
    parameter int TABLE_DEPTH  = spsu_pkg::TABLE_DEPTH_DEF,
    parameter int SEGMENT_BITS = spsu_pkg::SEGMENT_BITS_DEF,
    parameter int PRIME_BITS   = spsu_pkg::PRIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spsu_pkg::t_op               i_op,
    output spsu_pkg::t_status           o_flags,
    input  logic [spsu_pkg::IDX_W-1:0]  i_wanted_index,
    input  logic                        i_cfg_we,
    input  logic [spsu_pkg::LIM_W-1:0]  i_cfg_wdata,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [spsu_pkg::VAL_W-1:0]  o_prime_value,
    output logic [spsu_pkg::CNT_W-1:0]  o_known_count,
    output logic                        o_status
);
    localparam int PB    = PRIME_BITS;
    localparam int TAW   = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int SAW   = $clog2(SEGMENT_BITS);
    localparam int SZW   = $clog2(SEGMENT_BITS + 1);
    localparam int SQ_W  = (PB > 32) ? 32 : PB;
    localparam int WW    = (2 * SQ_W > PB + 2) ? 2 * SQ_W : PB + 2;
    localparam int IW    = spsu_pkg::IDX_W;
    localparam int VW    = spsu_pkg::VAL_W;
    localparam int NW    = spsu_pkg::CNT_W;
    localparam int LW    = spsu_pkg::LIM_W;
    localparam logic [WW-1:0] PMASK = WW'({PB{1'b1}});

    logic [IW-1:0]     r_want;
    logic [CW-1:0]     r_count;
    logic [WW-1:0]     r_next_cand;
    logic [LW-1:0]     r_limit;
    logic [WW-1:0]     r_start, r_stop, r_pos;
    logic [SZW-1:0]    r_size, r_idx;
    logic [CW-1:0]     r_k;
    logic [PB-1:0]     r_p;
    logic [2*SQ_W-1:0] r_sq;
    logic              r_sq_hi;
    logic              r_seed_sel;
    logic [PB-1:0]     r_seed_val;
    logic              r_out_valid;
    logic [VW-1:0]     r_out_value;
    logic [NW-1:0]     r_out_count;
    logic              r_out_status;

    // Table RAM ports.
    logic              t_we, t_re;
    logic [TAW-1:0]    t_waddr, t_raddr;
    logic [PB-1:0]     t_wdata, t_rdata, tbl_rd;
    // Sieve RAM ports.
    logic              s_we, s_re, s_wdata, s_rdata;
    logic [SAW-1:0]    s_addr;
    // Divider.
    logic              div_done, div_q_lsb;
    logic [PB-1:0]     div_rem;

    logic [WW-1:0]     stop_a, stop_b, span, stop_c, base, first;
    logic [SZW-1:0]    lim_c, size_c;
    logic [2*SQ_W-1:0] sq_c;
    logic              full, scan_wr;

    assign tbl_rd = r_seed_sel ? r_seed_val : t_rdata;
    assign full   = r_count >= CW'(TABLE_DEPTH);

    // Segment bounds: last prime squared, clipped to the value range, made odd.
    assign sq_c   = (2*SQ_W)'(tbl_rd[SQ_W-1:0]) * (2*SQ_W)'(tbl_rd[SQ_W-1:0]);
    assign stop_a = r_sq_hi ? PMASK : ((WW'(r_sq) > PMASK) ? PMASK : WW'(r_sq));
    assign stop_b = stop_a[0] ? stop_a : stop_a - 1'b1;
    assign span   = ((stop_b - r_next_cand) >> 1) + 1'b1;

    always_comb begin
        if (r_limit == '0) begin
            lim_c = SZW'(1);
        end else if (32'(r_limit) > 32'(SEGMENT_BITS)) begin
            lim_c = SZW'(SEGMENT_BITS);
        end else begin
            lim_c = SZW'(r_limit);
        end
    end

    assign size_c = (span > WW'(lim_c)) ? lim_c : SZW'(span);
    assign stop_c = r_next_cand + ((WW'(size_c) - 1'b1) << 1);

    // Smallest odd multiple of the prime at or above the segment start.
    assign base  = r_start - WW'(div_rem);
    assign first = !div_q_lsb ? base + WW'(r_p) :
                   ((div_rem != '0) ? base + (WW'(r_p) << 1) : base);

    assign scan_wr = s_rdata && !full;

    always_comb begin
        t_re    = 1'b0;
        t_raddr = '0;
        case (i_op)
            spsu_pkg::OP_RD_LAST: begin
                t_re    = 1'b1;
                t_raddr = TAW'(r_count - 1'b1);
            end
            spsu_pkg::OP_RD_PRIME: begin
                t_re    = 1'b1;
                t_raddr = r_k[TAW-1:0];
            end
            spsu_pkg::OP_RD_ANS: begin
                t_re    = 1'b1;
                t_raddr = TAW'(r_want);
            end
            default: ;
        endcase
    end

    assign t_we    = (i_op == spsu_pkg::OP_SCAN_CHK) && scan_wr;
    assign t_waddr = r_count[TAW-1:0];
    assign t_wdata = PB'(r_start + (WW'(r_idx) << 1));

    always_comb begin
        s_we    = 1'b0;
        s_re    = 1'b0;
        s_wdata = 1'b0;
        s_addr  = r_idx[SAW-1:0];
        case (i_op)
            spsu_pkg::OP_FILL: begin
                s_we    = 1'b1;
                s_wdata = 1'b1;
            end
            spsu_pkg::OP_STRIKE: begin
                s_we   = 1'b1;
                s_addr = r_pos[SAW-1:0];
            end
            spsu_pkg::OP_SCAN_RD: begin
                s_re = 1'b1;
            end
            default: ;
        endcase
    end

    spsu_ram #(.WIDTH(PB), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (t_we),
        .i_waddr(t_waddr),
        .i_wdata(t_wdata),
        .i_re   (t_re),
        .i_raddr(t_raddr),
        .o_rdata(t_rdata)
    );

    spsu_ram #(.WIDTH(1), .DEPTH(SEGMENT_BITS)) u_sieve (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_addr),
        .i_wdata(s_wdata),
        .i_re   (s_re),
        .i_raddr(s_addr),
        .o_rdata(s_rdata)
    );

    spsu_div #(.PRIME_BITS(PB)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_op == spsu_pkg::OP_DIV_START),
        .i_dividend(r_start[PB-1:0]),
        .i_divisor (tbl_rd),
        .o_done    (div_done),
        .o_rem     (div_rem),
        .o_q_lsb   (div_q_lsb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CW'(spsu_pkg::SEED_COUNT);
            r_next_cand <= WW'(spsu_pkg::FIRST_UNSIEVED);
            r_limit     <= spsu_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_op == spsu_pkg::OP_SCAN_CHK && scan_wr) begin
                r_count <= r_count + 1'b1;
            end
            if (i_op == spsu_pkg::OP_COMMIT) begin
                r_next_cand <= r_stop + WW'(2);
            end
            if (i_op == spsu_pkg::OP_OUT_OK || i_op == spsu_pkg::OP_OUT_ERR) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // Entries below the seed count come from the constant table.
        if (t_re) begin
            r_seed_sel <= 32'(t_raddr) < 32'(spsu_pkg::SEED_COUNT);
            r_seed_val <= PB'(spsu_pkg::seed_prime(t_raddr[3:0]));
        end

        case (i_op)
            spsu_pkg::OP_LOAD: r_want <= i_wanted_index;
            spsu_pkg::OP_SQUARE: begin
                r_sq    <= sq_c;
                r_sq_hi <= (tbl_rd >> SQ_W) != '0;
            end
            spsu_pkg::OP_SIZE: begin
                r_start <= r_next_cand;
                r_stop  <= stop_c;
                r_size  <= size_c;
                r_idx   <= '0;
                r_k     <= CW'(1);
            end
            spsu_pkg::OP_FILL:      r_idx <= r_idx + 1'b1;
            spsu_pkg::OP_RD_PRIME:  r_idx <= '0;
            spsu_pkg::OP_DIV_START: r_p   <= tbl_rd;
            spsu_pkg::OP_FIRST: begin
                if (first > r_stop) begin
                    r_pos <= WW'(r_size);
                end else begin
                    r_pos <= (first - r_start) >> 1;
                end
            end
            spsu_pkg::OP_STRIKE:   r_pos <= r_pos + WW'(r_p);
            spsu_pkg::OP_K_NEXT:   r_k   <= r_k + 1'b1;
            spsu_pkg::OP_SCAN_CHK: r_idx <= r_idx + 1'b1;
            spsu_pkg::OP_OUT_OK: begin
                r_out_value  <= VW'(tbl_rd);
                r_out_count  <= NW'(r_count);
                r_out_status <= 1'b0;
            end
            spsu_pkg::OP_OUT_ERR: begin
                r_out_value  <= '0;
                r_out_count  <= NW'(r_count);
                r_out_status <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_flags.want_oor   = 32'(r_want) >= 32'(TABLE_DEPTH);
    assign o_flags.want_known = 32'(r_want) < 32'(r_count);
    assign o_flags.full       = full;
    assign o_flags.exhausted  = r_next_cand > stop_b;
    assign o_flags.fill_last  = r_idx == r_size - 1'b1;
    assign o_flags.k_done     = r_k >= r_count;
    assign o_flags.div_done   = div_done;
    assign o_flags.strike_go  = r_pos < WW'(r_size);
    assign o_flags.scan_end   = (r_idx == r_size - 1'b1) ||
                                ((r_count + CW'(scan_wr)) >= CW'(TABLE_DEPTH));
    assign o_flags.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_prime_value = r_out_value;
    assign o_known_count = r_out_count;
    assign o_status      = r_out_status;
endmodule

// ===== hdl/spsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// spsu_ctrl
// Sequencer that steps the datapath through lookup and segment sieving.
// ----------------------------------------------------------------------------
module spsu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spsu_pkg::t_status i_status,
    output spsu_pkg::t_op     o_op
);
    spsu_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spsu_pkg::ST_IDLE:
                if (i_in_valid) n_state = spsu_pkg::ST_CHECK;
            spsu_pkg::ST_CHECK: begin
                if (i_status.want_oor) begin
                    n_state = spsu_pkg::ST_ERR;
                end else if (i_status.want_known) begin
                    n_state = spsu_pkg::ST_ANS_RD;
                end else if (i_status.full) begin
                    n_state = spsu_pkg::ST_ERR;
                end else begin
                    n_state = spsu_pkg::ST_LAST_RD;
                end
            end
            spsu_pkg::ST_LAST_RD: n_state = spsu_pkg::ST_SQ;
            spsu_pkg::ST_SQ:      n_state = spsu_pkg::ST_SIZE;
            spsu_pkg::ST_SIZE:
                n_state = i_status.exhausted ? spsu_pkg::ST_ERR : spsu_pkg::ST_FILL;
            spsu_pkg::ST_FILL:
                if (i_status.fill_last) n_state = spsu_pkg::ST_KRD;
            spsu_pkg::ST_KRD:
                n_state = i_status.k_done ? spsu_pkg::ST_SCAN_RD : spsu_pkg::ST_KDIV;
            spsu_pkg::ST_KDIV:  n_state = spsu_pkg::ST_KWAIT;
            spsu_pkg::ST_KWAIT:
                if (i_status.div_done) n_state = spsu_pkg::ST_KFIRST;
            spsu_pkg::ST_KFIRST: n_state = spsu_pkg::ST_STRIKE;
            spsu_pkg::ST_STRIKE:
                if (!i_status.strike_go) n_state = spsu_pkg::ST_KRD;
            spsu_pkg::ST_SCAN_RD: n_state = spsu_pkg::ST_SCAN_CHK;
            spsu_pkg::ST_SCAN_CHK:
                n_state = i_status.scan_end ? spsu_pkg::ST_COMMIT : spsu_pkg::ST_SCAN_RD;
            spsu_pkg::ST_COMMIT: n_state = spsu_pkg::ST_CHECK;
            spsu_pkg::ST_ANS_RD: n_state = spsu_pkg::ST_ANS;
            spsu_pkg::ST_ANS:
                if (i_status.out_free) n_state = spsu_pkg::ST_IDLE;
            spsu_pkg::ST_ERR:
                if (i_status.out_free) n_state = spsu_pkg::ST_IDLE;
            default: n_state = spsu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_op       = spsu_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            spsu_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = spsu_pkg::OP_LOAD;
            end
            spsu_pkg::ST_LAST_RD: o_op = spsu_pkg::OP_RD_LAST;
            spsu_pkg::ST_SQ:      o_op = spsu_pkg::OP_SQUARE;
            spsu_pkg::ST_SIZE:    o_op = spsu_pkg::OP_SIZE;
            spsu_pkg::ST_FILL:    o_op = spsu_pkg::OP_FILL;
            spsu_pkg::ST_KRD:     o_op = spsu_pkg::OP_RD_PRIME;
            spsu_pkg::ST_KDIV:    o_op = spsu_pkg::OP_DIV_START;
            spsu_pkg::ST_KFIRST:  o_op = spsu_pkg::OP_FIRST;
            spsu_pkg::ST_STRIKE:
                o_op = i_status.strike_go ? spsu_pkg::OP_STRIKE : spsu_pkg::OP_K_NEXT;
            spsu_pkg::ST_SCAN_RD:  o_op = spsu_pkg::OP_SCAN_RD;
            spsu_pkg::ST_SCAN_CHK: o_op = spsu_pkg::OP_SCAN_CHK;
            spsu_pkg::ST_COMMIT:   o_op = spsu_pkg::OP_COMMIT;
            spsu_pkg::ST_ANS_RD:   o_op = spsu_pkg::OP_RD_ANS;
            spsu_pkg::ST_ANS:
                if (i_status.out_free) o_op = spsu_pkg::OP_OUT_OK;
            spsu_pkg::ST_ERR:
                if (i_status.out_free) o_op = spsu_pkg::OP_OUT_ERR;
            default: o_op = spsu_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spsu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== hdl/spsu_checker.sv =====
// ----------------------------------------------------------------------------
// spsu_checker
// Port-level assertions for the prime sieve unit, bound to the top level.
// ----------------------------------------------------------------------------
module spsu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [spsu_pkg::VAL_W-1:0]  i_prime_value,
    input logic                        i_status
);
    // A stalled result stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_prime_value))
        else $error("result dropped or changed while stalled");

    // Error results carry a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_prime_value == '0)
        else $error("error result with nonzero value");

    // Good results are two or odd.
    a_ok_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_status |-> (i_prime_value == 2) || i_prime_value[0])
        else $error("good result is not a plausible prime");

    // Only one request is in flight at a time.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while one is in flight");
endmodule

bind segmented_prime_sieve_unit spsu_checker u_spsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_prime_value(o_res.prime_value),
    .i_status     (o_res.status)
);
